>>> sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// types, constants and saturation functions shared by the stack calculator modules
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int unsigned ValueWidth = 48;

   typedef logic signed [ValueWidth-1:0] value_type;

   typedef enum logic [3:0] {
      ACT_PUSH    = 4'd0,
      ACT_ADD     = 4'd1,
      ACT_SUB     = 4'd2,
      ACT_MUL     = 4'd3,
      ACT_DIV     = 4'd4,
      ACT_MOD     = 4'd5,
      ACT_SHOW    = 4'd6,
      ACT_DUP     = 4'd7,
      ACT_SWAP    = 4'd8,
      ACT_CLEAR   = 4'd9,
      ACT_EOL     = 4'd10,
      ACT_RECALL  = 4'd11,
      ACT_LATEST  = 4'd12,
      ACT_ASSIGN  = 4'd13,
      ACT_UNKNOWN = 4'd14,
      ACT_SPARE   = 4'd15
   } action_type;

   // request as classified by the front end
   typedef struct packed {
      action_type action;
      value_type  number_value;
      logic [4:0] variable_index;
      logic       bad_index;
   } request_type;

   localparam value_type ValueMax = {1'b0, {(ValueWidth-1){1'b1}}};
   localparam value_type ValueMin = {1'b1, {(ValueWidth-1){1'b0}}};

   // saturate a 50-bit signed sum into the value range
   function automatic value_type sat_sum(input logic signed [ValueWidth+1:0] s);
      if (s > $signed({{2{1'b0}}, ValueMax}))
         sat_sum = ValueMax;
      else if (s < $signed({{2{1'b1}}, ValueMin}))
         sat_sum = ValueMin;
      else
         sat_sum = s[ValueWidth-1:0];
   endfunction

   // magnitude and sign to value, saturated; mag is 130 bits wide
   function automatic value_type from_mag(input logic [129:0] mag, input logic neg);
      logic [ValueWidth-1:0] lim;
      logic [ValueWidth-1:0] lo;
      lim = neg ? ValueMin : ValueMax;
      if (mag > {82'd0, lim})
         lo = lim;
      else
         lo = mag[ValueWidth-1:0];
      from_mag = neg ? value_type'(-lo) : value_type'(lo);
   endfunction

endpackage

>>> sv/rpn_front.sv
// ----------------------------------------------------------------------------
// rpn_front
// accepts requests, classifies recall indexes, and queues them for the back end
// ----------------------------------------------------------------------------
module rpn_front #(
   parameter int unsigned VARIABLE_COUNT = 26
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [3:0]           req_action,
   input  logic signed [47:0]   req_number_value,
   input  logic [4:0]           req_variable_index,
   output logic                 q_valid,
   input  logic                 q_take,
   output rpn_pkg::request_type q_data
);
   import rpn_pkg::*;

   // two-entry queue
   request_type entry_ff [2];
   request_type entry_in;
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic       push_en, pop_en;

   assign req_stall = (count_ff == 2'd2);
   assign push_en   = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop_en    = q_valid && q_take;
   assign q_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in.action         = action_type'(req_action);
      entry_in.number_value   = req_number_value;
      entry_in.variable_index = req_variable_index;
      entry_in.bad_index      = ({27'd0, req_variable_index} >= VARIABLE_COUNT);
      rd_ptr_in = rd_ptr_ff ^ pop_en;
      wr_ptr_in = wr_ptr_ff ^ push_en;
      count_in  = count_ff + {1'b0, push_en} - {1'b0, pop_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
      if (push_en) entry_ff[wr_ptr_ff] <= entry_in;
   end

endmodule

>>> sv/rpn_mul.sv
// ----------------------------------------------------------------------------
// rpn_mul
// sequential fixed-point multiplier, 24x24 partial products, one per cycle
// ----------------------------------------------------------------------------
module rpn_mul #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rpn_pkg::value_type  op_a,
   input  rpn_pkg::value_type  op_b,
   output logic                done,
   output rpn_pkg::value_type  result
);
   import rpn_pkg::*;

   logic [47:0] x_ff, y_ff;
   logic        neg_ff;
   logic [96:0] acc_ff;
   logic [47:0] prod_ff;
   logic [2:0]  step_ff;
   logic        busy_ff, round_ff;
   logic [23:0] xs, ys;
   logic [96:0] scaled, rounded;

   always_comb begin
      xs = step_ff[1] ? x_ff[47:24] : x_ff[23:0];
      ys = step_ff[0] ? y_ff[47:24] : y_ff[23:0];
      if (FRACTION_BITS > 0)
         rounded = acc_ff + (97'd1 << (FRACTION_BITS - 1));
      else
         rounded = acc_ff;
      scaled = rounded >> FRACTION_BITS;
   end

   assign done   = round_ff;
   assign result = from_mag({33'd0, scaled}, neg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         round_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               busy_ff  <= 1'b0;
               round_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         x_ff   <= op_a[47] ? 48'(-op_a) : op_a;
         y_ff   <= op_b[47] ? 48'(-op_b) : op_b;
         neg_ff <= op_a[47] ^ op_b[47];
         acc_ff <= 97'd0;
      end else if (busy_ff) begin
         // stage 0..3 multiply, each registered product accumulated in the following step
         prod_ff <= xs * ys;
         if (step_ff != 3'd0) begin
            unique case (step_ff)
               3'd1: acc_ff <= acc_ff + {49'd0, prod_ff};
               3'd2, 3'd3: acc_ff <= acc_ff + ({49'd0, prod_ff} << 24);
               default: acc_ff <= acc_ff + ({49'd0, prod_ff} << 48);
            endcase
         end
      end
   end

endmodule

>>> sv/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// radix-2 restoring divider for fixed-point divide and remainder
// ----------------------------------------------------------------------------
module rpn_div #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                want_mod,
   input  rpn_pkg::value_type  op_a,
   input  rpn_pkg::value_type  op_b,
   output logic                done,
   output rpn_pkg::value_type  result
);
   import rpn_pkg::*;

   localparam int unsigned NumBits = 48 + FRACTION_BITS;
   localparam int unsigned CntW    = $clog2(NumBits + 1);

   logic [NumBits-1:0] num_ff, quo_ff;
   logic [48:0]        rem_ff;
   logic [47:0]        d_ff;
   logic               neg_ff, sign_a_ff, mod_ff, busy_ff, done_ff;
   logic [CntW-1:0]    cnt_ff;
   logic [48:0]        trial;
   logic [49:0]        diff;

   always_comb begin
      trial = {rem_ff[47:0], num_ff[NumBits-1]};
      diff  = {1'b0, trial} - {2'b00, d_ff};
   end

   assign done   = done_ff;
   assign result = mod_ff ? from_mag({81'd0, rem_ff}, sign_a_ff)
                          : from_mag(130'(quo_ff), neg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(NumBits);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         // remainder uses the unscaled dividend
         num_ff    <= want_mod ? NumBits'(op_a[47] ? 48'(-op_a) : op_a)
                               : (NumBits'(op_a[47] ? 48'(-op_a) : op_a) << FRACTION_BITS);
         d_ff      <= op_b[47] ? 48'(-op_b) : op_b;
         neg_ff    <= op_a[47] ^ op_b[47];
         sign_a_ff <= op_a[47];
         mod_ff    <= want_mod;
         rem_ff    <= '0;
         quo_ff    <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         if (!diff[49]) begin
            rem_ff <= diff[48:0];
            quo_ff <= {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[NumBits-2:0], 1'b0};
         end
      end
   end

endmodule

>>> sv/rpn_back.sv
// ----------------------------------------------------------------------------
// rpn_back
// executes queued requests against the stack memory and variables
// ----------------------------------------------------------------------------
module rpn_back #(
   parameter int unsigned STACK_DEPTH    = 128,
   parameter int unsigned VARIABLE_COUNT = 26,
   parameter int unsigned FRACTION_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_take,
   input  rpn_pkg::request_type q_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_print_valid,
   output logic signed [47:0]   rsp_print_value,
   output logic [1:0]           rsp_underflow_count,
   output logic                 rsp_overflow_flag,
   output logic                 rsp_zero_divisor_flag,
   output logic                 rsp_bad_variable_flag,
   output logic                 rsp_swap_short_flag,
   output logic                 rsp_unknown_flag
);
   import rpn_pkg::*;

   localparam int unsigned SpW  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned IdxW = $clog2(STACK_DEPTH);
   localparam int unsigned VarW = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RD1   = 8'b0000_0010,
      ST_RD2   = 8'b0000_0100,
      ST_EXEC  = 8'b0000_1000,
      ST_WAIT  = 8'b0001_0000,
      ST_WR1   = 8'b0010_0000,
      ST_WR2   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   value_type stack_mem [STACK_DEPTH];
   value_type rd_data_ff;
   value_type var_ff [VARIABLE_COUNT];
   value_type latest_ff;
   logic      prev_var_ff;
   logic [4:0] prev_idx_ff;
   logic [SpW-1:0] sp_ff;
   request_type req_ff;

   // top (b) and second (a) operands as read from the stack
   value_type b_ff, a_ff;
   logic [1:0] under_ff;
   logic      over_ff, zd_ff, badv_ff, short_ff, unk_ff, pv_ff;
   value_type pval_ff;
   // values to write back, in push order
   value_type w1_ff, w2_ff;
   logic      w1_en_ff, w2_en_ff;

   logic      mem_we;
   logic [IdxW-1:0] mem_waddr, mem_raddr;
   value_type mem_wdata;
   logic      mul_start, div_start, mul_done, div_done;
   value_type mul_res, div_res;
   value_type sum_res, dif_res;
   logic      out_busy_ff;
   logic      arith_busy_ff;
   logic      arith_hold;
   logic      rsp_load;

   assign rsp_valid = out_busy_ff;
   assign q_take    = (state_ff == ST_IDLE) && q_valid;
   assign rsp_load  = (state_ff == ST_DONE) && (!out_busy_ff || !rsp_stall);

   always_comb begin
      sum_res = sat_sum(50'(a_ff) + 50'(b_ff));
      dif_res = sat_sum(50'(a_ff) - 50'(b_ff));
   end

   rpn_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(a_ff), .op_b(b_ff), .done(mul_done), .result(mul_res));

   rpn_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .want_mod(req_ff.action == ACT_MOD),
      .op_a(a_ff), .op_b(b_ff), .done(div_done), .result(div_res));

   // number of operands a request pops from the stack
   function automatic logic [1:0] pops_of(input request_type r, input logic pv);
      unique case (r.action)
         ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_SWAP: pops_of = 2'd2;
         ACT_ASSIGN: pops_of = pv ? 2'd2 : 2'd1;
         ACT_SHOW, ACT_DUP, ACT_EOL: pops_of = 2'd1;
         default: pops_of = 2'd0;
      endcase
   endfunction

   // start pulse on the first execute cycle only
   assign mul_start = (state_ff == ST_EXEC) && !arith_busy_ff &&
                      (req_ff.action == ACT_MUL);
   assign div_start = (state_ff == ST_EXEC) && !arith_busy_ff &&
                      (req_ff.action == ACT_DIV || req_ff.action == ACT_MOD) &&
                      (b_ff != '0);

   // stay in execute while a multiply or divide is running
   always_comb begin
      arith_hold = (req_ff.action == ACT_MUL || req_ff.action == ACT_DIV ||
                    req_ff.action == ACT_MOD) && !zd_ff && !mul_done && !div_done;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sp_ff[IdxW-1:0];
      mem_wdata = w1_ff;
      if (sp_ff < SpW'(STACK_DEPTH)) begin
         if (state_ff == ST_WR1 && w1_en_ff) begin
            mem_we = 1'b1;
         end else if (state_ff == ST_WR2 && w2_en_ff) begin
            mem_we    = 1'b1;
            mem_wdata = w2_ff;
         end
      end
      mem_raddr = IdxW'(sp_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= stack_mem[mem_raddr];
   end

   // response register handshake
   always_ff @(posedge clock) begin
      if (reset)
         out_busy_ff <= 1'b0;
      else if (rsp_load)
         out_busy_ff <= 1'b1;
      else if (!rsp_stall)
         out_busy_ff <= 1'b0;
   end

   // sequencer: pop operands, execute, push results, respond
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sp_ff         <= '0;
         latest_ff     <= '0;
         prev_var_ff   <= 1'b0;
         prev_idx_ff   <= 5'd0;
         arith_busy_ff <= 1'b0;
         for (int i = 0; i < VARIABLE_COUNT; i++) var_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  req_ff   <= q_data;
                  under_ff <= 2'd0;
                  over_ff  <= 1'b0;
                  zd_ff    <= 1'b0;
                  badv_ff  <= 1'b0;
                  short_ff <= 1'b0;
                  unk_ff   <= 1'b0;
                  pv_ff    <= 1'b0;
                  pval_ff  <= '0;
                  w1_en_ff <= 1'b0;
                  w2_en_ff <= 1'b0;
                  a_ff     <= '0;
                  b_ff     <= '0;
                  state_ff <= ST_RD1;
               end
            end
            ST_RD1: begin
               // read address settles, data lands next cycle
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               // first pop (top)
               if (pops_of(req_ff, prev_var_ff) != 2'd0) begin
                  if (sp_ff != '0) begin
                     b_ff  <= rd_data_ff;
                     sp_ff <= sp_ff - 1'b1;
                  end else begin
                     under_ff <= under_ff + 2'd1;
                  end
               end
               // swap on a single element leaves the stack as it was
               if (req_ff.action == ACT_SWAP && sp_ff == SpW'(1))
                  short_ff <= 1'b1;
               if (pops_of(req_ff, prev_var_ff) == 2'd2 &&
                   (req_ff.action != ACT_SWAP || sp_ff >= SpW'(2)))
                  state_ff <= ST_WAIT;
               else
                  state_ff <= ST_EXEC;
            end
            ST_WAIT: begin
               // second pop after the read port catches up
               if (!w1_en_ff) begin
                  w1_en_ff <= 1'b1;
                  state_ff <= ST_WAIT;
               end else begin
                  w1_en_ff <= 1'b0;
                  if (req_ff.action == ACT_SWAP) begin
                     a_ff  <= rd_data_ff;
                     sp_ff <= sp_ff - 1'b1;
                  end else if ((req_ff.action == ACT_DIV || req_ff.action == ACT_MOD)
                               && b_ff == '0) begin
                     zd_ff <= 1'b1;
                  end else if (req_ff.action == ACT_ASSIGN && prev_var_ff
                               && prev_idx_ff < 5'(VARIABLE_COUNT)) begin
                     if (sp_ff != '0) begin
                        var_ff[prev_idx_ff[VarW-1:0]] <= rd_data_ff;
                        sp_ff <= sp_ff - 1'b1;
                     end else begin
                        var_ff[prev_idx_ff[VarW-1:0]] <= '0;
                        under_ff <= under_ff + 2'd1;
                     end
                  end else if (sp_ff != '0) begin
                     a_ff  <= rd_data_ff;
                     sp_ff <= sp_ff - 1'b1;
                  end else begin
                     under_ff <= under_ff + 2'd1;
                  end
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (!arith_hold) state_ff <= ST_WR1;
               unique case (req_ff.action)
                  ACT_PUSH: begin w1_ff <= req_ff.number_value; w1_en_ff <= 1'b1; end
                  ACT_ADD:  begin w1_ff <= sum_res; w1_en_ff <= 1'b1; end
                  ACT_SUB:  begin w1_ff <= dif_res; w1_en_ff <= 1'b1; end
                  ACT_MUL, ACT_DIV, ACT_MOD: begin
                     if (mul_done || div_done) begin
                        w1_ff         <= mul_done ? mul_res : div_res;
                        w1_en_ff      <= 1'b1;
                        arith_busy_ff <= 1'b0;
                     end else if (!zd_ff) begin
                        arith_busy_ff <= 1'b1;
                     end
                  end
                  ACT_SHOW: begin
                     if (under_ff == 2'd0) begin
                        pv_ff    <= 1'b1;
                        pval_ff  <= b_ff;
                        w1_ff    <= b_ff;
                        w1_en_ff <= 1'b1;
                     end
                  end
                  ACT_DUP: begin
                     if (under_ff == 2'd0) begin
                        w1_ff <= b_ff; w1_en_ff <= 1'b1;
                        w2_ff <= b_ff; w2_en_ff <= 1'b1;
                     end
                  end
                  ACT_SWAP: begin
                     if (short_ff) begin
                        // one element: restore it
                        w1_ff <= b_ff; w1_en_ff <= 1'b1;
                     end else if (under_ff == 2'd0) begin
                        w1_ff <= b_ff; w1_en_ff <= 1'b1;
                        w2_ff <= a_ff; w2_en_ff <= 1'b1;
                     end
                  end
                  ACT_CLEAR: sp_ff <= '0;
                  ACT_EOL: begin
                     pv_ff     <= 1'b1;
                     pval_ff   <= b_ff;
                     latest_ff <= b_ff;
                  end
                  ACT_RECALL: begin
                     if (req_ff.bad_index) unk_ff <= 1'b1;
                     else begin
                        w1_ff    <= var_ff[req_ff.variable_index[VarW-1:0]];
                        w1_en_ff <= 1'b1;
                     end
                  end
                  ACT_LATEST: begin w1_ff <= latest_ff; w1_en_ff <= 1'b1; end
                  ACT_ASSIGN: begin
                     if (!(prev_var_ff && prev_idx_ff < 5'(VARIABLE_COUNT)))
                        badv_ff <= 1'b1;
                  end
                  default: unk_ff <= 1'b1;
               endcase
            end
            ST_WR1: begin
               if (w1_en_ff) begin
                  if (sp_ff < SpW'(STACK_DEPTH)) sp_ff <= sp_ff + 1'b1;
                  else over_ff <= 1'b1;
               end
               state_ff <= ST_WR2;
            end
            ST_WR2: begin
               if (w2_en_ff) begin
                  if (sp_ff < SpW'(STACK_DEPTH)) sp_ff <= sp_ff + 1'b1;
                  else over_ff <= 1'b1;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_print_valid       <= pv_ff;
                  rsp_print_value       <= pv_ff ? pval_ff : '0;
                  rsp_underflow_count   <= (req_ff.action == ACT_SHOW ||
                                            req_ff.action == ACT_DUP ||
                                            req_ff.action == ACT_SWAP) &&
                                           under_ff != 2'd0 ? 2'd1 : under_ff;
                  rsp_overflow_flag     <= over_ff;
                  rsp_zero_divisor_flag <= zd_ff;
                  rsp_bad_variable_flag <= badv_ff;
                  rsp_swap_short_flag   <= short_ff;
                  rsp_unknown_flag      <= unk_ff;
                  prev_var_ff <= (req_ff.action == ACT_RECALL) && !req_ff.bad_index;
                  if (req_ff.action == ACT_RECALL && !req_ff.bad_index)
                     prev_idx_ff <= req_ff.variable_index;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> sv/rpn_stack_calculator_unit.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit
// reverse polish stack calculator over pre-tokenized requests, q31.16 values
// ----------------------------------------------------------------------------
// sequence: read, execute, write back, respond; two-operand requests
// (add, sub, mul, div, mod, swap on two or more, assign after recall) add a
// second pop; mul waits on the multiplier, div and mod on the one-bit-per-cycle
// restoring divider. The back end takes one request at a time, after the last has
// responded; two-entry queue in front; a stalled response holds the back end
// reset: synchronous; clears stack pointer, variables, latest value, queue
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit #(
   parameter int unsigned STACK_DEPTH    = 128,
   parameter int unsigned VARIABLE_COUNT = 26,
   parameter int unsigned FRACTION_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_action,
   input  logic signed [47:0] req_number_value,
   input  logic [4:0]         req_variable_index,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_print_valid,
   output logic signed [47:0] rsp_print_value,
   output logic [1:0]         rsp_underflow_count,
   output logic               rsp_overflow_flag,
   output logic               rsp_zero_divisor_flag,
   output logic               rsp_bad_variable_flag,
   output logic               rsp_swap_short_flag,
   output logic               rsp_unknown_flag
);
   import rpn_pkg::*;

   // queue between front end and execution back end
   logic        q_valid;
   logic        q_take;
   request_type q_data;

   // front end: accept and classify
   rpn_front #(.VARIABLE_COUNT(VARIABLE_COUNT)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_number_value(req_number_value),
      .req_variable_index(req_variable_index),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data));

   // back end: stack memory, arithmetic units, response register
   rpn_back #(
      .STACK_DEPTH(STACK_DEPTH),
      .VARIABLE_COUNT(VARIABLE_COUNT),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_print_valid(rsp_print_valid), .rsp_print_value(rsp_print_value),
      .rsp_underflow_count(rsp_underflow_count),
      .rsp_overflow_flag(rsp_overflow_flag),
      .rsp_zero_divisor_flag(rsp_zero_divisor_flag),
      .rsp_bad_variable_flag(rsp_bad_variable_flag),
      .rsp_swap_short_flag(rsp_swap_short_flag),
      .rsp_unknown_flag(rsp_unknown_flag));

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rpn stack calculator: directed tokens, then
// random expression sequences, predicted in-bench and compared per response
// ----------------------------------------------------------------------------
module testbench;
   import rpn_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Depth   = 128;
   localparam int unsigned VarCount = 26;
   localparam int unsigned FracBits = 16;

   typedef struct packed {
      logic            print_valid;
      logic [47:0]     print_value;
      logic [1:0]      underflow_count;
      logic            overflow_flag;
      logic            zero_divisor_flag;
      logic            bad_variable_flag;
      logic            swap_short_flag;
      logic            unknown_flag;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_action = 4'd0;
   logic signed [47:0] req_number_value = '0;
   logic [4:0] req_variable_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_print_valid;
   logic signed [47:0] rsp_print_value;
   logic [1:0] rsp_underflow_count;
   logic rsp_overflow_flag, rsp_zero_divisor_flag, rsp_bad_variable_flag;
   logic rsp_swap_short_flag, rsp_unknown_flag;

   rpn_stack_calculator_unit uut (.*);

   // predictor state
   logic [47:0] calc_stack [Depth];
   int unsigned calc_sp;
   logic [47:0] calc_vars [VarCount];
   logic [47:0] calc_latest;
   logic        calc_prev_var;
   logic [4:0]  calc_prev_idx;
   int unsigned pop_misses;
   logic        push_lost;

   response_type pending_responses [$];
   int unsigned mismatch_count = 0;
   bit idle_enabled = 1'b1;

   initial forever #4 clock = ~clock;

   // generous fixed limit: ~840 requests * (divider latency + stalls)
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [47:0] sat64(longint x);
      if (x > 64'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
      if (x < -64'sd140737488355328) return 48'h8000_0000_0000;
      return x[47:0];
   endfunction

   function automatic logic [47:0] from_magnitude(logic [127:0] m, logic neg);
      logic [47:0] lim;
      lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      if (m > {80'd0, lim}) m = {80'd0, lim};
      return neg ? 48'(-m[47:0]) : m[47:0];
   endfunction

   function automatic logic [47:0] fixed_mul(logic [47:0] ra, logic [47:0] rb);
      logic signed [47:0] a, b;
      logic [127:0] p;
      a = ra; b = rb;
      p = 128'(a < 0 ? -96'(a) : 96'(a)) * 128'(b < 0 ? -96'(b) : 96'(b));
      p = (p + (128'd1 << (FracBits - 1))) >> FracBits;
      return from_magnitude(p, (a < 0) != (b < 0));
   endfunction

   function automatic logic [47:0] fixed_div(logic [47:0] ra, logic [47:0] rb);
      logic signed [47:0] a, b;
      logic [127:0] x, d;
      a = ra; b = rb;
      x = 128'(a < 0 ? -96'(a) : 96'(a)) << FracBits;
      d = 128'(b < 0 ? -96'(b) : 96'(b));
      return from_magnitude(x / d, (a < 0) != (b < 0));
   endfunction

   function automatic logic [47:0] fixed_mod(logic [47:0] ra, logic [47:0] rb);
      logic signed [47:0] a, b;
      logic [127:0] x, d;
      a = ra; b = rb;
      x = 128'(a < 0 ? -96'(a) : 96'(a));
      d = 128'(b < 0 ? -96'(b) : 96'(b));
      return from_magnitude(x % d, a < 0);
   endfunction

   function automatic void stack_push(logic [47:0] v);
      if (calc_sp < Depth) begin
         calc_stack[calc_sp] = v;
         calc_sp++;
      end else push_lost = 1'b1;
   endfunction

   function automatic logic [47:0] stack_pop();
      if (calc_sp > 0) begin
         calc_sp--;
         return calc_stack[calc_sp];
      end
      pop_misses++;
      return '0;
   endfunction

   // compute the response of one request and advance predictor state
   function automatic response_type calc_predict(logic [3:0] act, logic [47:0] num,
                                                 logic [4:0] idx);
      response_type r;
      logic [47:0] a, b, v;
      logic is_var;
      int unsigned under;
      r = '0;
      is_var = 1'b0;
      under = 0;
      pop_misses = 0;
      push_lost = 1'b0;
      case (action_type'(act))
         ACT_PUSH: stack_push(num);
         ACT_ADD, ACT_SUB, ACT_MUL: begin
            b = stack_pop();
            a = stack_pop();
            if (act == ACT_ADD)
               stack_push(sat64(longint'($signed(a)) + longint'($signed(b))));
            else if (act == ACT_SUB)
               stack_push(sat64(longint'($signed(a)) - longint'($signed(b))));
            else
               stack_push(fixed_mul(a, b));
         end
         ACT_DIV, ACT_MOD: begin
            b = stack_pop();
            if (b == 0) r.zero_divisor_flag = 1'b1;
            else begin
               a = stack_pop();
               stack_push(act == ACT_DIV ? fixed_div(a, b) : fixed_mod(a, b));
            end
         end
         ACT_SHOW: begin
            if (calc_sp > 0) begin
               r.print_valid = 1'b1;
               r.print_value = calc_stack[calc_sp - 1];
            end else under = 1;
         end
         ACT_DUP: begin
            if (calc_sp > 0) begin
               v = stack_pop();
               stack_push(v);
               stack_push(v);
            end else under = 1;
         end
         ACT_SWAP: begin
            if (calc_sp == 0) under = 1;
            else if (calc_sp == 1) r.swap_short_flag = 1'b1;
            else begin
               a = stack_pop();
               b = stack_pop();
               stack_push(a);
               stack_push(b);
            end
         end
         ACT_CLEAR: calc_sp = 0;
         ACT_EOL: begin
            v = stack_pop();
            r.print_valid = 1'b1;
            r.print_value = v;
            calc_latest = v;
         end
         ACT_RECALL: begin
            if (idx < VarCount) begin
               stack_push(calc_vars[idx]);
               is_var = 1'b1;
               calc_prev_idx = idx;
            end else r.unknown_flag = 1'b1;
         end
         ACT_LATEST: stack_push(calc_latest);
         ACT_ASSIGN: begin
            void'(stack_pop());
            if (calc_prev_var && calc_prev_idx < VarCount)
               calc_vars[calc_prev_idx] = stack_pop();
            else r.bad_variable_flag = 1'b1;
         end
         default: r.unknown_flag = 1'b1;
      endcase
      calc_prev_var = is_var;
      under += pop_misses;
      if (under > 3) under = 3;
      r.underflow_count = under[1:0];
      r.overflow_flag = push_lost;
      return r;
   endfunction

   function automatic void calc_reset();
      calc_sp = 0;
      calc_latest = '0;
      calc_prev_var = 1'b0;
      calc_prev_idx = '0;
      foreach (calc_vars[i]) calc_vars[i] = '0;
   endfunction

   // send one request; prediction is made when it is accepted
   // valid stays high on return so back-to-back requests need no gap
   task automatic send_request(action_type act, logic [47:0] num = '0,
                               logic [4:0] idx = '0);
      int unsigned gap;
      if (idle_enabled && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_number_value <= num;
      req_variable_index <= idx;
      do @(posedge clock); while (req_stall);
      pending_responses.push_back(calc_predict(act, num, idx));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(negedge clock);
   endtask

   // random stall bursts on the response side
   initial begin
      forever begin
         @(negedge clock);
         if (idle_enabled && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      response_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_print_valid, rsp_print_value, rsp_underflow_count,
                rsp_overflow_flag, rsp_zero_divisor_flag, rsp_bad_variable_flag,
                rsp_swap_short_flag, rsp_unknown_flag};
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_responses.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected pv=%b val=%h un=%0d ov=%b zd=%b bv=%b sw=%b uk=%b",
                           want.print_valid, want.print_value, want.underflow_count,
                           want.overflow_flag, want.zero_divisor_flag,
                           want.bad_variable_flag, want.swap_short_flag,
                           want.unknown_flag,
                           "\n          actual   pv=%b val=%h un=%0d ov=%b zd=%b bv=%b sw=%b uk=%b",
                           got.print_valid, got.print_value, got.underflow_count,
                           got.overflow_flag, got.zero_divisor_flag,
                           got.bad_variable_flag, got.swap_short_flag,
                           got.unknown_flag);
            end
         end
      end
   end

   function automatic logic [47:0] random_value();
      case ($urandom_range(0, 5))
         0: return 48'h7FFF_FFFF_FFFF;
         1: return 48'h8000_0000_0000;
         2: return '0;
         3: return 48'($signed($urandom_range(0, 20)) - 10) << FracBits;
         4: return {16'($urandom), 32'($urandom)} >>> $urandom_range(0, 30);
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   // arithmetic at the value extremes, including saturation
   task automatic test_arithmetic();
      send_request(ACT_PUSH, 48'h7FFF_FFFF_FFFF);
      send_request(ACT_PUSH, 48'h0000_0001_0000);
      send_request(ACT_ADD);
      send_request(ACT_PUSH, 48'h8000_0000_0000);
      send_request(ACT_SUB);
      send_request(ACT_PUSH, 48'hFFFF_FFFE_8000);
      send_request(ACT_MUL);
      send_request(ACT_PUSH, 48'h0000_0003_0000);
      send_request(ACT_DIV);
      send_request(ACT_PUSH, 48'hFFFF_FFFF_0001);
      send_request(ACT_MOD);
      send_request(ACT_EOL);
   endtask

   // stack edge cases: empty pops, zero divisor, short swap, bad assign, unknown
   task automatic test_special_cases();
      send_request(ACT_CLEAR);
      send_request(ACT_ADD);
      send_request(ACT_SHOW);
      send_request(ACT_DUP);
      send_request(ACT_SWAP);
      send_request(ACT_EOL);
      send_request(ACT_PUSH, 48'h0000_0005_0000);
      send_request(ACT_SWAP);
      send_request(ACT_PUSH, '0);
      send_request(ACT_DIV);
      send_request(ACT_PUSH, '0);
      send_request(ACT_MOD);
      send_request(ACT_ASSIGN);
      send_request(ACT_RECALL, '0, 5'd31);
      send_request(ACT_UNKNOWN);
      send_request(ACT_SPARE);
   endtask

   // variables: assign after recall, recall back, latest value
   task automatic test_variables();
      send_request(ACT_PUSH, 48'h1234_5678_9ABC);
      send_request(ACT_RECALL, '0, 5'd25);
      send_request(ACT_ASSIGN);
      send_request(ACT_RECALL, '0, 5'd25);
      send_request(ACT_EOL);
      send_request(ACT_LATEST);
      send_request(ACT_SHOW);
   endtask

   // fill past full depth, then dup on a full stack
   task automatic test_stack_overflow();
      send_request(ACT_CLEAR);
      repeat (Depth + 2) send_request(ACT_PUSH, random_value());
      send_request(ACT_DUP);
      send_request(ACT_CLEAR);
   endtask

   // random expressions: mostly well-formed, some noise
   task automatic test_random_expressions(int unsigned count);
      int unsigned n;
      n = 0;
      while (n < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               send_request(ACT_PUSH, random_value());
               send_request(ACT_PUSH, random_value());
               send_request(action_type'($urandom_range(ACT_ADD, ACT_MOD)));
               n += 3;
            end
            3: begin
               send_request(ACT_PUSH, random_value());
               send_request(ACT_RECALL, '0, 5'($urandom_range(0, VarCount - 1)));
               send_request(ACT_ASSIGN);
               n += 3;
            end
            4: begin
               send_request(ACT_RECALL, '0, 5'($urandom_range(0, VarCount - 1)));
               n++;
            end
            5: begin
               send_request(ACT_EOL);
               n++;
            end
            6: begin
               send_request(action_type'($urandom_range(ACT_SHOW, ACT_LATEST)));
               n++;
            end
            7: begin
               send_request(action_type'($urandom_range(0, 15)), random_value(),
                            5'($urandom));
               n++;
            end
            default: begin
               send_request(ACT_PUSH, random_value());
               n++;
            end
         endcase
      end
   endtask

   initial begin
      calc_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_arithmetic();
      test_special_cases();
      test_variables();
      // sender holds off until the calculator has answered everything
      wait_drained();
      test_stack_overflow();
      test_random_expressions(550);
      // last part without any idling
      idle_enabled = 1'b0;
      test_random_expressions(120);
      wait_drained();
      repeat (200) @(negedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
sv/rpn_pkg.sv
sv/rpn_front.sv
sv/rpn_mul.sv
sv/rpn_div.sv
sv/rpn_back.sv
sv/rpn_stack_calculator_unit.sv
tb/testbench.sv
